// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the tokenizer rtl
// no dependencies; the checks are compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ===== hw/rtl/etok_pkg.sv =====
// shared types, codes and character helpers of the expression tokenizer
// no dependencies; used by etok_lexer and expression_tokenizer_top
package etok_pkg;

  // most results one input byte can cause
  localparam int MAX_RES = 5;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int RES_FIFO_DEPTH = 8;

  // result kinds
  localparam logic [1:0] K_BYTE = 2'd0;
  localparam logic [1:0] K_END  = 2'd1;
  localparam logic [1:0] K_ERR  = 2'd2;
  localparam logic [1:0] K_DONE = 2'd3;

  // token classes
  localparam logic [3:0] C_ARITH = 4'd0;
  localparam logic [3:0] C_BOOL  = 4'd1;
  localparam logic [3:0] C_CMP   = 4'd2;
  localparam logic [3:0] C_STR   = 4'd3;
  localparam logic [3:0] C_NUM   = 4'd4;
  localparam logic [3:0] C_LPAR  = 4'd5;
  localparam logic [3:0] C_RPAR  = 4'd6;
  localparam logic [3:0] C_ARR   = 4'd7;
  localparam logic [3:0] C_IDENT = 4'd8;
  localparam logic [3:0] C_COMMA = 4'd9;

  // error codes
  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_UNKNOWN  = 3'd1;
  localparam logic [2:0] E_BOOL     = 3'd2;
  localparam logic [2:0] E_CMP      = 3'd3;
  localparam logic [2:0] E_TRAIL    = 3'd4;
  localparam logic [2:0] E_OPEN_STR = 3'd5;
  localparam logic [2:0] E_OPEN_ARR = 3'd6;

  // characters
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_PIPE   = 8'h7c;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LBRK   = 8'h5b;
  localparam logic [7:0] CH_RBRK   = 8'h5d;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_UNDER  = 8'h5f;

  // lexer mode: pending lookahead or open token
  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_ERROR = 4'd1,
    M_AMP   = 4'd2,
    M_PIPE  = 4'd3,
    M_BANG  = 4'd4,
    M_LT    = 4'd5,
    M_GT    = 4'd6,
    M_EQ    = 4'd7,
    M_STR   = 4'd8,
    M_ARR   = 4'd9,
    M_NUM   = 4'd10,
    M_IDENT = 4'd11
  } mode_t;

  // one result beat without its run flag
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] cls;
    logic [7:0] lex;
    logic [2:0] err;
  } res_t;

  // results of one byte handed from the lexer to the result queue
  typedef struct packed {
    logic [CNT_W-1:0]         count;
    res_t [MAX_RES-1:0]       res;
    mode_t                    mode_next;
  } lex_out_t;

  // what a byte does when it starts a new token
  typedef struct packed {
    logic [1:0]  n;
    res_t [1:0]  r;
    mode_t       mode;
  } start_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || is_alpha(c);
  endfunction

  function automatic res_t mk_byte(input logic [3:0] cls, input logic [7:0] c);
    res_t r;
    r.kind = K_BYTE;
    r.cls  = cls;
    r.lex  = c;
    r.err  = E_NONE;
    return r;
  endfunction

  function automatic res_t mk_end(input logic [3:0] cls);
    res_t r;
    r.kind = K_END;
    r.cls  = cls;
    r.lex  = 8'h00;
    r.err  = E_NONE;
    return r;
  endfunction

  function automatic res_t mk_err(input logic [2:0] code);
    res_t r;
    r.kind = K_ERR;
    r.cls  = C_ARITH;
    r.lex  = 8'h00;
    r.err  = code;
    return r;
  endfunction

  function automatic res_t mk_done();
    res_t r;
    r.kind = K_DONE;
    r.cls  = C_ARITH;
    r.lex  = 8'h00;
    r.err  = E_NONE;
    return r;
  endfunction

  // byte seen with no token open
  function automatic start_t start_token(input logic [7:0] c, input logic last);
    start_t s;
    s = '0;
    s.mode = M_IDLE;
    case (c) inside
      CH_SP, CH_TAB, CH_CR, CH_LF: begin
      end
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_PCT: begin
        if (last) begin
          s.n    = 2'd1;
          s.r[0] = mk_err(E_TRAIL);
          s.mode = M_ERROR;
        end else begin
          s.n    = 2'd2;
          s.r[0] = mk_byte(C_ARITH, c);
          s.r[1] = mk_end(C_ARITH);
        end
      end
      CH_AMP:   s.mode = M_AMP;
      CH_PIPE:  s.mode = M_PIPE;
      CH_BANG:  s.mode = M_BANG;
      CH_LBRK:  s.mode = M_ARR;
      CH_QUOTE: s.mode = M_STR;
      CH_LT:    s.mode = M_LT;
      CH_GT:    s.mode = M_GT;
      CH_EQ:    s.mode = M_EQ;
      CH_LPAR: begin
        s.n    = 2'd2;
        s.r[0] = mk_byte(C_LPAR, c);
        s.r[1] = mk_end(C_LPAR);
      end
      CH_RPAR: begin
        s.n    = 2'd2;
        s.r[0] = mk_byte(C_RPAR, c);
        s.r[1] = mk_end(C_RPAR);
      end
      CH_COMMA: begin
        s.n    = 2'd2;
        s.r[0] = mk_byte(C_COMMA, c);
        s.r[1] = mk_end(C_COMMA);
      end
      default: begin
        s.n = 2'd1;
        if (is_digit(c) || (c == CH_DOT)) begin
          s.r[0] = mk_byte(C_NUM, c);
          s.mode = M_NUM;
        end else if (is_alpha(c) || (c == CH_UNDER)) begin
          s.r[0] = mk_byte(C_IDENT, c);
          s.mode = M_IDENT;
        end else begin
          s.r[0] = mk_err(E_UNKNOWN);
          s.mode = M_ERROR;
        end
      end
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/etok_lexer.sv =====
// per-byte lexing logic: mode and byte in, up to five results and next mode out
// depends on etok_pkg
module etok_lexer import etok_pkg::*; (
  input  mode_t       mode,
  input  logic [7:0]  ch,
  input  logic        last,
  output lex_out_t    lo
);

  start_t            st;
  res_t              res [MAX_RES];
  logic [CNT_W-1:0]  n;
  mode_t             mode_n;
  logic              use_start;
  logic [7:0]        want;
  logic [7:0]        held;
  logic [3:0]        pair_cls;
  logic [2:0]        pair_err;

  always_comb begin
    st        = start_token(ch, last);
    n         = '0;
    mode_n    = mode;
    use_start = 1'b0;
    for (int k = 0; k < MAX_RES; k++) begin
      res[k] = '0;
    end

    // doubled operators: && || ==
    case (mode)
      M_AMP:   want = CH_AMP;
      M_PIPE:  want = CH_PIPE;
      default: want = CH_EQ;
    endcase
    pair_cls = (mode == M_EQ) ? C_CMP : C_BOOL;
    pair_err = (mode == M_EQ) ? E_CMP : E_BOOL;
    held     = (mode == M_LT) ? CH_LT : CH_GT;

    // resolve pending lookahead or extend the open token
    case (mode)
      M_ERROR: begin
      end
      M_AMP, M_PIPE, M_EQ: begin
        if (ch == want) begin
          res[0] = mk_byte(pair_cls, want);
          res[1] = mk_byte(pair_cls, want);
          res[2] = mk_end(pair_cls);
          n      = CNT_W'(3);
          mode_n = M_IDLE;
        end else begin
          res[0] = mk_err(pair_err);
          n      = CNT_W'(1);
          mode_n = M_ERROR;
        end
      end
      M_BANG: begin
        if (ch == CH_EQ) begin
          res[0] = mk_byte(C_CMP, CH_BANG);
          res[1] = mk_byte(C_CMP, CH_EQ);
          res[2] = mk_end(C_CMP);
          n      = CNT_W'(3);
          mode_n = M_IDLE;
        end else if ((ch == CH_BANG) || is_alnum(ch) || (ch == CH_LPAR)) begin
          res[0]    = mk_byte(C_BOOL, CH_BANG);
          res[1]    = mk_end(C_BOOL);
          n         = CNT_W'(2);
          use_start = 1'b1;
        end else begin
          res[0] = mk_err(E_BOOL);
          n      = CNT_W'(1);
          mode_n = M_ERROR;
        end
      end
      M_LT, M_GT: begin
        res[0] = mk_byte(C_CMP, held);
        if (ch == CH_EQ) begin
          res[1] = mk_byte(C_CMP, CH_EQ);
          res[2] = mk_end(C_CMP);
          n      = CNT_W'(3);
          mode_n = M_IDLE;
        end else begin
          res[1]    = mk_end(C_CMP);
          n         = CNT_W'(2);
          use_start = 1'b1;
        end
      end
      M_STR: begin
        n = CNT_W'(1);
        if (ch == CH_QUOTE) begin
          res[0] = mk_end(C_STR);
          mode_n = M_IDLE;
        end else begin
          res[0] = mk_byte(C_STR, ch);
        end
      end
      M_ARR: begin
        n = CNT_W'(1);
        if (ch == CH_RBRK) begin
          res[0] = mk_end(C_ARR);
          mode_n = M_IDLE;
        end else begin
          res[0] = mk_byte(C_ARR, ch);
        end
      end
      M_NUM: begin
        n = CNT_W'(1);
        if (is_digit(ch) || (ch == CH_DOT)) begin
          res[0] = mk_byte(C_NUM, ch);
        end else begin
          res[0]    = mk_end(C_NUM);
          use_start = 1'b1;
        end
      end
      M_IDENT: begin
        n = CNT_W'(1);
        if (is_alnum(ch) || (ch == CH_UNDER)) begin
          res[0] = mk_byte(C_IDENT, ch);
        end else begin
          res[0]    = mk_end(C_IDENT);
          use_start = 1'b1;
        end
      end
      default: begin
        use_start = 1'b1;
      end
    endcase

    // byte starts a new token
    if (use_start) begin
      for (int j = 0; j < 2; j++) begin
        if (2'(j) < st.n) begin
          res[n] = st.r[j];
          n      = n + CNT_W'(1);
        end
      end
      mode_n = st.mode;
    end

    // end of expression: close or report the open token, then finish
    if (last) begin
      case (mode_n)
        M_AMP, M_PIPE, M_BANG: begin
          res[n] = mk_err(E_BOOL);
          n      = n + CNT_W'(1);
        end
        M_LT, M_GT, M_EQ: begin
          res[n] = mk_err(E_CMP);
          n      = n + CNT_W'(1);
        end
        M_STR: begin
          res[n] = mk_err(E_OPEN_STR);
          n      = n + CNT_W'(1);
        end
        M_ARR: begin
          res[n] = mk_err(E_OPEN_ARR);
          n      = n + CNT_W'(1);
        end
        M_NUM: begin
          res[n] = mk_end(C_NUM);
          n      = n + CNT_W'(1);
        end
        M_IDENT: begin
          res[n] = mk_end(C_IDENT);
          n      = n + CNT_W'(1);
        end
        default: begin
        end
      endcase
      res[n] = mk_done();
      n      = n + CNT_W'(1);
      mode_n = M_IDLE;
    end

    lo.count     = n;
    lo.mode_next = mode_n;
    for (int k = 0; k < MAX_RES; k++) begin
      lo.res[k] = res[k];
    end
  end

endmodule

// ===== hw/rtl/expression_tokenizer_top.sv =====
// Streaming tokenizer for rule expressions (top level; uses etok_pkg, etok_lexer and
// assert_macros.svh). A byte beat is taken into an input register, lexed there by
// combinational logic against the held lexer mode, and its results (up to five) are
// written at once into a result queue of FIFO_DEPTH entries (a power of two, at least
// 8); results leave one per output beat, the last one of each byte marked by last_of_run.
// A byte's results pass from the input register through the result queue to the output.
// Input beats are taken every cycle as long as the queue has room for five more results,
// so with the output unstalled the sustained rate is one byte per cycle while bytes
// average at most one result each; otherwise the single output beat per cycle sets the pace.
`include "assert_macros.svh"

module expression_tokenizer_top import etok_pkg::*; #(
  parameter int FIFO_DEPTH = RES_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  input  logic        end_of_expression,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [3:0]  token_class,
  output logic [7:0]  lexeme_byte,
  output logic [2:0]  error_code,
  output logic        last_of_run
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    res_t r;
    logic last;
  } entry_t;

  logic              item_valid;
  logic [7:0]        item_char;
  logic              item_last;
  mode_t             mode;
  lex_out_t          lo;
  logic              fire;
  logic              pop;
  logic              in_take;
  logic [CW-1:0]     used;
  logic [CW-1:0]     room;
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  entry_t            mem [FIFO_DEPTH];
  entry_t            head;

  // byte lexing
  etok_lexer u_lexer (
    .mode (mode),
    .ch   (item_char),
    .last (item_last),
    .lo   (lo)
  );

  // handshakes
  assign pop      = out_valid && !out_stall;
  assign room     = CW'(FIFO_DEPTH) - used + CW'(pop);
  assign fire     = item_valid && (room >= CW'(MAX_RES));
  assign in_stall = item_valid && !fire;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= in_take || (item_valid && !fire);
    end
    if (in_take) begin
      item_char <= char_in;
      item_last <= end_of_expression;
    end
  end

  // lexer mode
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
    end else if (fire) begin
      mode <= lo.mode_next;
    end
  end

  // result queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (fire) begin
        wr_ptr <= wr_ptr + AW'(lo.count);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      used <= used + (fire ? CW'(lo.count) : CW'(0)) - CW'(pop);
    end
  end

  // result queue storage: all results of a byte written together
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (fire && (CNT_W'(i) < lo.count)) begin
        mem[wr_ptr + AW'(i)] <= '{r: lo.res[i],
                                  last: (CNT_W'(i) == CNT_W'(lo.count - CNT_W'(1)))};
      end
    end
  end

  // output beat
  assign head        = mem[rd_ptr];
  assign out_valid   = (used != '0);
  assign result_kind = head.r.kind;
  assign token_class = head.r.cls;
  assign lexeme_byte = head.r.lex;
  assign error_code  = head.r.err;
  assign last_of_run = head.last;

  // checks
  `ASSERT_NEVER(a_no_overfill, clk, rst, used > CW'(FIFO_DEPTH), "result queue overfilled")
  `ASSERT_AT(a_done_ends_run, clk, rst, (out_valid && (result_kind == K_DONE)) |-> last_of_run, "finished beat not last of run")
  `ASSERT_AT(a_last_gives_result, clk, rst, (fire && item_last) |-> (lo.count != '0), "final byte gave no result")
  `ASSERT_AT(a_idle_after_end, clk, rst, (fire && item_last) |=> (mode == M_IDLE), "mode not idle after expression end")
  `ASSERT_AT(a_stall_needs_item, clk, rst, in_stall |-> item_valid, "input stalled with empty register")

endmodule

// ===== bench/expression_tokenizer_top_test.sv =====
// testbench for expression_tokenizer_top: directed and random rule expressions, with
// results checked beat by beat against a lexer model kept inside the bench
// depends on etok_pkg and the tokenizer rtl
module expression_tokenizer_top_test;
  import etok_pkg::*;

  // one expected or observed result beat
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] cls;
    logic [7:0] lex;
    logic [2:0] err;
    logic       last;
  } beat_t;

  localparam string IDENT_HEAD = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string IDENT_TAIL = "azAZ_09xQ7";
  localparam string NUM_CHARS  = "0123456789.";
  localparam string ARITH_OPS  = "+-*/^%";

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_in = 8'h00;
  logic       end_of_expression = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] result_kind;
  logic [3:0] token_class;
  logic [7:0] lexeme_byte;
  logic [2:0] error_code;
  logic       last_of_run;

  // lexer model state and pending results
  mode_t      lex_mode = M_IDLE;
  beat_t      token_beats_due[$];
  beat_t      byte_run[$];
  logic [7:0] expr_text[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int bytes_sent = 0;
  int live_bytes = 0;
  int expr_count = 0;
  int beats_checked = 0;
  int mismatches = 0;

  expression_tokenizer_top dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .char_in           (char_in),
    .end_of_expression (end_of_expression),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .result_kind       (result_kind),
    .token_class       (token_class),
    .lexeme_byte       (lexeme_byte),
    .error_code        (error_code),
    .last_of_run       (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- lexer model

  function automatic logic digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void add_beat(input logic [1:0] kind, input logic [3:0] cls,
                                   input logic [7:0] lex, input logic [2:0] err);
    beat_t b;
    b.kind = kind;
    b.cls  = cls;
    b.lex  = lex;
    b.err  = err;
    b.last = 1'b0;
    byte_run.push_back(b);
  endfunction

  function automatic void add_lexeme(input logic [3:0] cls, input logic [7:0] c);
    add_beat(K_BYTE, cls, c, E_NONE);
  endfunction

  function automatic void add_token_end(input logic [3:0] cls);
    add_beat(K_END, cls, 8'h00, E_NONE);
  endfunction

  function automatic void raise_error(input logic [2:0] code);
    add_beat(K_ERR, C_ARITH, 8'h00, code);
    lex_mode = M_ERROR;
  endfunction

  // byte seen with no token open
  function automatic void begin_token(input logic [7:0] c, input logic last);
    case (c)
      CH_SP, CH_TAB, CH_CR, CH_LF: ;
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_PCT: begin
        if (last) begin
          raise_error(E_TRAIL);
        end else begin
          add_lexeme(C_ARITH, c);
          add_token_end(C_ARITH);
        end
      end
      CH_AMP:   lex_mode = M_AMP;
      CH_PIPE:  lex_mode = M_PIPE;
      CH_BANG:  lex_mode = M_BANG;
      CH_LBRK:  lex_mode = M_ARR;
      CH_QUOTE: lex_mode = M_STR;
      CH_LT:    lex_mode = M_LT;
      CH_GT:    lex_mode = M_GT;
      CH_EQ:    lex_mode = M_EQ;
      CH_LPAR: begin
        add_lexeme(C_LPAR, c);
        add_token_end(C_LPAR);
      end
      CH_RPAR: begin
        add_lexeme(C_RPAR, c);
        add_token_end(C_RPAR);
      end
      CH_COMMA: begin
        add_lexeme(C_COMMA, c);
        add_token_end(C_COMMA);
      end
      default: begin
        if (digit_char(c) || c == CH_DOT) begin
          add_lexeme(C_NUM, c);
          lex_mode = M_NUM;
        end else if (letter_char(c) || c == CH_UNDER) begin
          add_lexeme(C_IDENT, c);
          lex_mode = M_IDENT;
        end else begin
          raise_error(E_UNKNOWN);
        end
      end
    endcase
  endfunction

  // doubled operator: && || ==
  function automatic void close_pair(input logic [7:0] c, input logic [7:0] want,
                                     input logic [3:0] cls, input logic [2:0] code);
    if (c == want) begin
      add_lexeme(cls, want);
      add_lexeme(cls, want);
      add_token_end(cls);
      lex_mode = M_IDLE;
    end else begin
      raise_error(code);
    end
  endfunction

  function automatic void lex_one(input logic [7:0] c, input logic last);
    logic [7:0] held;
    case (lex_mode)
      M_ERROR: ;
      M_AMP:   close_pair(c, CH_AMP, C_BOOL, E_BOOL);
      M_PIPE:  close_pair(c, CH_PIPE, C_BOOL, E_BOOL);
      M_EQ:    close_pair(c, CH_EQ, C_CMP, E_CMP);
      M_BANG: begin
        if (c == CH_EQ) begin
          add_lexeme(C_CMP, CH_BANG);
          add_lexeme(C_CMP, CH_EQ);
          add_token_end(C_CMP);
          lex_mode = M_IDLE;
        end else if (c == CH_BANG || digit_char(c) || letter_char(c) || c == CH_LPAR) begin
          add_lexeme(C_BOOL, CH_BANG);
          add_token_end(C_BOOL);
          lex_mode = M_IDLE;
          begin_token(c, last);
        end else begin
          raise_error(E_BOOL);
        end
      end
      M_LT, M_GT: begin
        held = (lex_mode == M_LT) ? CH_LT : CH_GT;
        lex_mode = M_IDLE;
        add_lexeme(C_CMP, held);
        if (c == CH_EQ) begin
          add_lexeme(C_CMP, CH_EQ);
          add_token_end(C_CMP);
        end else begin
          add_token_end(C_CMP);
          begin_token(c, last);
        end
      end
      M_STR: begin
        if (c == CH_QUOTE) begin
          add_token_end(C_STR);
          lex_mode = M_IDLE;
        end else begin
          add_lexeme(C_STR, c);
        end
      end
      M_ARR: begin
        if (c == CH_RBRK) begin
          add_token_end(C_ARR);
          lex_mode = M_IDLE;
        end else begin
          add_lexeme(C_ARR, c);
        end
      end
      M_NUM: begin
        if (digit_char(c) || c == CH_DOT) begin
          add_lexeme(C_NUM, c);
        end else begin
          add_token_end(C_NUM);
          lex_mode = M_IDLE;
          begin_token(c, last);
        end
      end
      M_IDENT: begin
        if (digit_char(c) || letter_char(c) || c == CH_UNDER) begin
          add_lexeme(C_IDENT, c);
        end else begin
          add_token_end(C_IDENT);
          lex_mode = M_IDLE;
          begin_token(c, last);
        end
      end
      default: begin
        lex_mode = M_IDLE;
        begin_token(c, last);
      end
    endcase
  endfunction

  // end of expression: close or report what is open
  function automatic void close_expression();
    case (lex_mode)
      M_AMP, M_PIPE, M_BANG: raise_error(E_BOOL);
      M_LT, M_GT, M_EQ:      raise_error(E_CMP);
      M_STR:                 raise_error(E_OPEN_STR);
      M_ARR:                 raise_error(E_OPEN_ARR);
      M_NUM:                 add_token_end(C_NUM);
      M_IDENT:               add_token_end(C_IDENT);
      default: ;
    endcase
    add_beat(K_DONE, C_ARITH, 8'h00, E_NONE);
    lex_mode = M_IDLE;
  endfunction

  // results one accepted byte causes, queued in order
  function automatic void tokenize_byte(input logic [7:0] c, input logic last);
    byte_run.delete();
    if (lex_mode != M_ERROR) live_bytes++;
    lex_one(c, last);
    if (last) close_expression();
    if (byte_run.size() > 0) byte_run[byte_run.size() - 1].last = 1'b1;
    foreach (byte_run[i]) token_beats_due.push_back(byte_run[i]);
  endfunction

  // ---------------------------------------------------------------- byte sender

  task automatic send_beat(input logic [7:0] c, input logic eoe);
    int gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 8) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    char_in <= c;
    end_of_expression <= eoe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokenize_byte(c, eoe);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1);
    expr_count++;
  endtask

  task automatic send_expression();
    foreach (expr_text[i]) send_beat(expr_text[i], i == expr_text.size() - 1);
    expr_count++;
  endtask

  // ---------------------------------------------------------------- random text

  function automatic logic [7:0] pick_char(input string chars);
    return chars[$urandom_range(chars.len() - 1)];
  endfunction

  function automatic logic [7:0] byte_except(input logic [7:0] avoid);
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == avoid) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) expr_text.push_back(s[i]);
  endfunction

  // mostly well-formed tokens, with some noise and broken operators
  function automatic void build_expression();
    int n_tok;
    int len;
    expr_text.delete();
    n_tok = $urandom_range(6, 1);
    for (int t = 0; t < n_tok; t++) begin
      len = $urandom_range(3);
      case ($urandom_range(13))
        0: begin
          expr_text.push_back(pick_char(IDENT_HEAD));
          repeat (len) expr_text.push_back(pick_char(IDENT_TAIL));
        end
        1: repeat (len + 1) expr_text.push_back(pick_char(NUM_CHARS));
        2: expr_text.push_back(pick_char(ARITH_OPS));
        3: push_text($urandom_range(1) ? "&&" : "||");
        4: begin
          expr_text.push_back(CH_BANG);
          case ($urandom_range(3))
            0: expr_text.push_back(pick_char(IDENT_HEAD));
            1: expr_text.push_back(pick_char(NUM_CHARS));
            2: expr_text.push_back(CH_LPAR);
            default: expr_text.push_back(CH_BANG);
          endcase
        end
        5: begin
          case ($urandom_range(5))
            0: push_text("<");
            1: push_text("<=");
            2: push_text(">");
            3: push_text(">=");
            4: push_text("==");
            default: push_text("!=");
          endcase
        end
        6: begin
          expr_text.push_back(CH_QUOTE);
          repeat (len) expr_text.push_back(byte_except(CH_QUOTE));
          expr_text.push_back(CH_QUOTE);
        end
        7: begin
          expr_text.push_back(CH_LBRK);
          repeat (len) expr_text.push_back(byte_except(CH_RBRK));
          expr_text.push_back(CH_RBRK);
        end
        8: expr_text.push_back(CH_LPAR);
        9: expr_text.push_back(CH_RPAR);
        10: expr_text.push_back(CH_COMMA);
        11: begin
          case ($urandom_range(3))
            0: expr_text.push_back(CH_SP);
            1: expr_text.push_back(CH_TAB);
            2: expr_text.push_back(CH_CR);
            default: expr_text.push_back(CH_LF);
          endcase
        end
        12: expr_text.push_back(8'($urandom_range(255)));
        default: begin
          expr_text.push_back(pick_char("&|=!"));
          expr_text.push_back(8'($urandom_range(255)));
        end
      endcase
      if ($urandom_range(3) == 0) expr_text.push_back(CH_SP);
    end
    // sometimes leave an operator or literal open at the end
    if ($urandom_range(99) < 15) expr_text.push_back(pick_char("+\"[<=&!>|"));
  endfunction

  // ---------------------------------------------------------------- receiver

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  task automatic flag_beat(input string why, input beat_t want, input beat_t got);
    if (mismatches < 10)
      $display("%s: want kind %0d class %0d byte %02h err %0d last %0b, ",
               why, want.kind, want.cls, want.lex, want.err, want.last,
               "got kind %0d class %0d byte %02h err %0d last %0b",
               got.kind, got.cls, got.lex, got.err, got.last);
    mismatches++;
  endtask

  // compare every accepted result beat with the oldest one due
  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    got = {result_kind, token_class, lexeme_byte, error_code, last_of_run};
    if (!rst && out_valid && !out_stall) begin
      beats_checked++;
      if (token_beats_due.size() == 0) begin
        flag_beat("result with none due", '0, got);
      end else begin
        want = token_beats_due.pop_front();
        if (got !== want) flag_beat("result mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // field extremes and several special cases in short directed expressions
  task automatic test_directed_cases();
    send_idle_pct = 0;
    stall_pct = 0;
    send_text("a_1>=.5,(b)");
    send_text("!x&&[]");
    send_text("\"\"-");
    send_beat(8'h00, 1'b0);
    send_beat(CH_UNDER, 1'b1);
    expr_count++;
    send_beat(8'hff, 1'b1);
    expr_count++;
    send_text("=a");
    send_text("\"s");
  endtask

  task automatic test_random_phase(input int sender_pct, input int receiver_pct,
                                   input int n_bytes);
    int start_live = live_bytes;
    send_idle_pct = sender_pct;
    stall_pct = receiver_pct;
    while (live_bytes - start_live < n_bytes) begin
      build_expression();
      send_expression();
    end
  endtask

  // output held off while bytes keep coming, so the result queue fills
  task automatic test_backpressure();
    int start_live = live_bytes;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 80;
    while (live_bytes - start_live < 40) begin
      build_expression();
      send_expression();
    end
  endtask

  initial begin
    int waited = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_phase(0, 0, 64);
    test_random_phase(46, 0, 64);
    test_random_phase(0, 46, 64);
    test_random_phase(6, 6, 64);
    test_backpressure();

    @(negedge clk);
    in_valid <= 1'b0;
    while (token_beats_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (token_beats_due.size() != 0) begin
      $display("%0d result beats never arrived", token_beats_due.size());
      mismatches++;
    end

    $display("%0d bytes in %0d expressions sent, %0d result beats checked",
             bytes_sent, expr_count, beats_checked);
    $display("phases: directed cases, free flow, sender gaps, receiver stalls, both, hold-off");
    if (mismatches == 0) begin
      $display("[expression_tokenizer_top] OK");
    end else begin
      $display("[expression_tokenizer_top] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("[expression_tokenizer_top] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/etok_pkg.sv
hw/rtl/etok_lexer.sv
hw/rtl/expression_tokenizer_top.sv
bench/expression_tokenizer_top_test.sv
